@@ design/ssfc_pkg.sv @@
// shared types, constants and font lookup for the seven-segment frame composer
package ssfc_pkg;

	// grid count default
	localparam int GRID_COUNT_DEF = 16;

	// input opcodes
	localparam logic [2:0] OP_COMPOSE     = 3'd0;
	localparam logic [2:0] OP_SET_LED     = 3'd1;
	localparam logic [2:0] OP_CLR_LED     = 3'd2;
	localparam logic [2:0] OP_TGL_LED     = 3'd3;
	localparam logic [2:0] OP_CLR_REFRESH = 3'd4;
	localparam logic [2:0] OP_REFRESH     = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_AUTO_INC  = 3'd0;
	localparam logic [2:0] REG_ADDR_SET  = 3'd1;
	localparam logic [2:0] REG_ON_LOW    = 3'd2;
	localparam logic [2:0] REG_ON_MED    = 3'd3;
	localparam logic [2:0] REG_ON_HIGH   = 3'd4;
	localparam logic [2:0] REG_BRIGHT    = 3'd5;

	// configuration reset values
	localparam logic [7:0] AUTO_INC_RST = 8'd64;
	localparam logic [7:0] ADDR_SET_RST = 8'd192;
	localparam logic [7:0] ON_LOW_RST   = 8'd136;
	localparam logic [7:0] ON_MED_RST   = 8'd140;
	localparam logic [7:0] ON_HIGH_RST  = 8'd143;

	// brightness codes
	localparam logic [1:0] BRIGHT_LOW = 2'd0;
	localparam logic [1:0] BRIGHT_MED = 2'd1;

	// glyph codes beyond the decimal digits
	localparam logic [3:0] GLYPH_L     = 4'd10;
	localparam logic [3:0] GLYPH_E     = 4'd11;
	localparam logic [3:0] GLYPH_BLANK = 4'd15;

	// digit segments a..g land in these grids
	localparam logic [3:0] SEG_GRID [7] = '{4'd14, 4'd13, 4'd1, 4'd10, 4'd7, 4'd12, 4'd11};
	// digit position to segment bit within a grid byte
	localparam logic [2:0] POS_BIT [4] = '{3'd1, 3'd2, 3'd3, 3'd0};

	// reciprocal of ten, exact for 16-bit values with a shift of 19
	localparam logic [31:0] RECIP10 = 32'd52429;
	localparam int RECIP10_SHIFT = 19;
	localparam int DIGIT_COUNT = 4;

	// commands from the controller to the datapath
	typedef struct packed {
		logic led_op;
		logic clr_all;
		logic cmp_load;
		logic dig_step;
		logic draw;
		logic emit;
	} ssfc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} ssfc_stat_t;

	// segment pattern of a glyph, blank for codes with no glyph
	function automatic logic [6:0] font(input logic [3:0] g);
		logic [6:0] m;
		case (g)
			4'd0:    m = 7'h3F;
			4'd1:    m = 7'h06;
			4'd2:    m = 7'h5B;
			4'd3:    m = 7'h4F;
			4'd4:    m = 7'h66;
			4'd5:    m = 7'h6D;
			4'd6:    m = 7'h7D;
			4'd7:    m = 7'h07;
			4'd8:    m = 7'h7F;
			4'd9:    m = 7'h6F;
			GLYPH_L: m = 7'h38;
			GLYPH_E: m = 7'h79;
			default: m = 7'h00;
		endcase
		return m;
	endfunction

endpackage

@@ design/ssfc_ctrl.sv @@
// controller state machine: sequences led edits, compose and refresh frames
module ssfc_ctrl
	import ssfc_pkg::*;
#(
	parameter int GRID_COUNT = GRID_COUNT_DEF,
	parameter int SEQ_W = $clog2(GRID_COUNT + 3)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  ssfc_stat_t       stat,
	output ssfc_cmd_t        cmd,
	output logic [SEQ_W-1:0] seq
);

	typedef enum logic [1:0] {S_IDLE, S_DIGIT, S_DRAW, S_EMIT} state_t;

	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(GRID_COUNT + 2);
	localparam logic [1:0] DIG_LAST = 2'(DIGIT_COUNT - 1);

	state_t           state_q;
	logic [SEQ_W-1:0] seq_q;
	logic [1:0]       cnt_q;
	logic             accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign seq = seq_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.led_op = accept && (opcode inside {OP_SET_LED, OP_CLR_LED, OP_TGL_LED});
		cmd.clr_all = accept && (opcode == OP_CLR_REFRESH);
		cmd.cmp_load = accept && (opcode == OP_COMPOSE);
		cmd.dig_step = (state_q == S_DIGIT);
		cmd.draw = (state_q == S_DRAW);
		cmd.emit = (state_q == S_EMIT) && stat.out_free;
	end

	// state, digit counter and frame sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seq_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					seq_q <= '0;
					if (accept) begin
						case (opcode)
							OP_COMPOSE:     state_q <= S_DIGIT;
							OP_CLR_REFRESH: state_q <= S_EMIT;
							OP_REFRESH:     state_q <= S_EMIT;
							default:        state_q <= S_IDLE;
						endcase
					end
				end
				S_DIGIT: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == DIG_LAST) begin
						state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (stat.out_free) begin
						seq_q <= seq_q + SEQ_W'(1);
						if (seq_q == SEQ_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/ssfc_dp.sv @@
// datapath: led buffer, config registers, digit extraction and output register
module ssfc_dp
	import ssfc_pkg::*;
#(
	parameter int GRID_COUNT = GRID_COUNT_DEF,
	parameter int SEQ_W = $clog2(GRID_COUNT + 3)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [2:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic [2:0]       opcode,
	input  logic [3:0]       segment,
	input  logic [4:0]       grid,
	input  logic [15:0]      error_flags,
	input  logic [3:0]       level,
	input  logic             level_view,
	input  logic [15:0]      speed,
	input  ssfc_cmd_t        cmd,
	input  logic [SEQ_W-1:0] seq,
	output ssfc_stat_t       stat,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       frame_byte,
	output logic             frame_start,
	output logic             frame_stop,
	output logic             last
);

	localparam int GRID_W = $clog2(GRID_COUNT);
	localparam logic [4:0] GRID_LIM = 5'(GRID_COUNT);
	localparam logic [SEQ_W-1:0] SEQ_ADDR = SEQ_W'(1);
	localparam logic [SEQ_W-1:0] SEQ_BUF_LAST = SEQ_W'(GRID_COUNT + 1);
	localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(GRID_COUNT + 2);

	logic [7:0]  buf_q [GRID_COUNT];
	logic [7:0]  auto_inc_q, addr_set_q, on_low_q, on_med_q, on_high_q;
	logic [1:0]  bright_q;
	logic [15:0] flags_q;
	logic [3:0]  level_q;
	logic        show_q;
	logic [15:0] rem_q;
	logic [3:0]  digs_q [DIGIT_COUNT];
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        start_q, stop_q, last_q;

	logic        led_ok;
	logic [GRID_W-1:0] led_idx;
	logic [7:0]  led_mask;
	logic [31:0] prod;
	logic [12:0] quot;
	logic [15:0] quot10;
	logic [15:0] diff;
	logic [3:0]  err_code;
	logic [3:0]  glyph [DIGIT_COUNT];
	logic [6:0]  gmask [DIGIT_COUNT];
	logic [SEQ_W-1:0] bidx;
	logic [7:0]  ctl_byte;
	logic [7:0]  next_byte;

	// single led operand checks
	assign led_ok = (segment < 4'd8) && (grid < GRID_LIM);
	assign led_idx = grid[GRID_W-1:0];
	assign led_mask = 8'b1 << segment[2:0];

	// one decimal digit per step by reciprocal multiply
	assign prod = 32'(rem_q) * RECIP10;
	assign quot = prod[RECIP10_SHIFT+12:RECIP10_SHIFT];
	assign quot10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
	assign diff = rem_q - quot10;

	// lowest set error flag among the low eight
	always_comb begin
		err_code = 4'd0;
		for (int b = 7; b >= 0; b--) begin
			if (flags_q[b]) begin
				err_code = 4'(b + 1);
			end
		end
	end

	// glyph choice per digit position
	always_comb begin
		for (int p = 0; p < DIGIT_COUNT; p++) begin
			glyph[p] = GLYPH_BLANK;
		end
		if (flags_q != 16'd0) begin
			glyph[1] = GLYPH_E;
			glyph[2] = err_code;
		end else if (level_q == 4'd0) begin
			glyph[1] = GLYPH_L;
			glyph[2] = 4'd0;
		end else if (show_q) begin
			if (level_q <= 4'd9) begin
				glyph[1] = GLYPH_L;
				glyph[2] = level_q;
			end else if (level_q == 4'd10) begin
				glyph[0] = GLYPH_L;
				glyph[1] = 4'd1;
				glyph[2] = 4'd0;
			end
		end else begin
			for (int p = 0; p < DIGIT_COUNT; p++) begin
				glyph[p] = digs_q[p];
			end
		end
	end

	// segment pattern of each chosen glyph
	always_comb begin
		for (int p = 0; p < DIGIT_COUNT; p++) begin
			gmask[p] = font(glyph[p]);
		end
	end

	// led buffer: clear all, single led edits and digit redraw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int gi = 0; gi < GRID_COUNT; gi++) begin
				buf_q[gi] <= 8'd0;
			end
		end else if (cmd.clr_all) begin
			for (int gi = 0; gi < GRID_COUNT; gi++) begin
				buf_q[gi] <= 8'd0;
			end
		end else if (cmd.led_op) begin
			if (led_ok) begin
				case (opcode)
					OP_SET_LED: buf_q[led_idx] <= buf_q[led_idx] | led_mask;
					OP_CLR_LED: buf_q[led_idx] <= buf_q[led_idx] & ~led_mask;
					OP_TGL_LED: buf_q[led_idx] <= buf_q[led_idx] ^ led_mask;
					default:    buf_q[led_idx] <= buf_q[led_idx];
				endcase
			end
		end else if (cmd.draw) begin
			for (int gi = 0; gi < GRID_COUNT; gi++) begin
				for (int j = 0; j < 7; j++) begin
					if (int'(SEG_GRID[j]) == gi) begin
						for (int p = 0; p < DIGIT_COUNT; p++) begin
							buf_q[gi][POS_BIT[p]] <= gmask[p][j];
						end
					end
				end
			end
		end
	end

	// compose operands and digit shift register
	always_ff @(posedge clk) begin
		if (cmd.cmp_load) begin
			flags_q <= error_flags;
			level_q <= level;
			show_q <= level_view;
			rem_q <= speed;
		end else if (cmd.dig_step) begin
			rem_q <= 16'(quot);
			digs_q[0] <= diff[3:0];
			for (int p = 1; p < DIGIT_COUNT; p++) begin
				digs_q[p] <= digs_q[p-1];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_inc_q <= AUTO_INC_RST;
			addr_set_q <= ADDR_SET_RST;
			on_low_q <= ON_LOW_RST;
			on_med_q <= ON_MED_RST;
			on_high_q <= ON_HIGH_RST;
			bright_q <= BRIGHT_LOW;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AUTO_INC: auto_inc_q <= cfg_data;
				REG_ADDR_SET: addr_set_q <= cfg_data;
				REG_ON_LOW:   on_low_q <= cfg_data;
				REG_ON_MED:   on_med_q <= cfg_data;
				REG_ON_HIGH:  on_high_q <= cfg_data;
				REG_BRIGHT:   bright_q <= cfg_data[1:0];
				default:      ;
			endcase
		end
	end

	// frame byte select
	assign bidx = seq - SEQ_W'(2);
	always_comb begin
		case (bright_q)
			BRIGHT_LOW: ctl_byte = on_low_q;
			BRIGHT_MED: ctl_byte = on_med_q;
			default:    ctl_byte = on_high_q;
		endcase
		if (seq == '0) begin
			next_byte = auto_inc_q;
		end else if (seq == SEQ_ADDR) begin
			next_byte = addr_set_q;
		end else if (seq == SEQ_LAST) begin
			next_byte = ctl_byte;
		end else begin
			next_byte = buf_q[bidx[GRID_W-1:0]];
		end
	end

	// output register
	assign stat.out_free = !out_valid_q || !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= next_byte;
			start_q <= (seq == '0) || (seq == SEQ_ADDR) || (seq == SEQ_LAST);
			stop_q <= (seq == '0) || (seq == SEQ_BUF_LAST) || (seq == SEQ_LAST);
			last_q <= (seq == SEQ_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign frame_byte = byte_q;
	assign frame_start = start_q;
	assign frame_stop = stop_q;
	assign last = last_q;

endmodule

@@ design/seven_segment_frame_composer_top.sv @@
// top level of the seven-segment frame composer
//
// Keeps a GRID_COUNT-byte led buffer (one byte per grid, one bit per segment)
// and produces the byte frames that load a display driver chip.
// Input channel (in_valid/in_stall) takes one item: an opcode plus operands.
// Set, clear and toggle of one led are done when the item is taken; in_stall stays low.
// Compose runs four digit steps of the reciprocal-of-ten multiply unit, then
// a redraw of the 28 digit leds; in_stall is high meanwhile.
// Refresh (and clear-all-and-refresh) emits GRID_COUNT+3 items on the output
// channel, one per cycle while out_stall is low; the first item passes the
// controller state register, then the output register. The frame sequencer
// is the limit: new items wait until the last byte is loaded into the output
// register. A stalled output item holds there and the sequencer waits.
// Config writes (cfg_write, cfg_index, cfg_data) are registered; the user must
// make them only while the block is idle, which the block does not enforce.
// Reset clears the led buffer, loads the default command bytes and leaves
// both channels empty.
module seven_segment_frame_composer_top
	import ssfc_pkg::*;
#(
	parameter int GRID_COUNT = GRID_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [3:0]  segment,
	input  logic [4:0]  grid,
	input  logic [15:0] error_flags,
	input  logic [3:0]  level,
	input  logic        level_view,
	input  logic [15:0] speed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_start,
	output logic        frame_stop,
	output logic        last
);

	localparam int SEQ_W = $clog2(GRID_COUNT + 3);

	ssfc_cmd_t        cmd;
	ssfc_stat_t       stat;
	logic [SEQ_W-1:0] seq;

	// controller
	ssfc_ctrl #(.GRID_COUNT(GRID_COUNT), .SEQ_W(SEQ_W)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.stat     (stat),
		.cmd      (cmd),
		.seq      (seq)
	);

	// datapath
	ssfc_dp #(.GRID_COUNT(GRID_COUNT), .SEQ_W(SEQ_W)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.segment     (segment),
		.grid        (grid),
		.error_flags (error_flags),
		.level       (level),
		.level_view  (level_view),
		.speed       (speed),
		.cmd         (cmd),
		.seq         (seq),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.frame_stop  (frame_stop),
		.last        (last)
	);

	// a refresh item holds off the input channel while its frame runs
	a_refresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_REFRESH || opcode == OP_CLR_REFRESH)
		|=> in_stall)
		else $error("refresh item did not block the input channel");

	// a single led edit finishes at once
	a_led_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall &&
		(opcode == OP_SET_LED || opcode == OP_CLR_LED || opcode == OP_TGL_LED)
		|=> !in_stall)
		else $error("led edit stalled the input channel");

	// the closing brightness byte is framed on both sides
	a_last_framed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> frame_start && frame_stop)
		else $error("last frame item lacks start or stop");

endmodule
